@@ rtl/core/stable_merge_sorter_defines.svh @@
// ----------------------------------------------------------------------------
// stable_merge_sorter_defines
// Assertion macros shared by the sorter RTL.
// ----------------------------------------------------------------------------
`ifndef STABLE_MERGE_SORTER_DEFINES_SVH
`define STABLE_MERGE_SORTER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SMS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SMS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/sms_pkg.sv @@
// ----------------------------------------------------------------------------
// sms_pkg
// Shared types and constants of the stable merge sorter.
// ----------------------------------------------------------------------------
package sms_pkg;

  localparam int unsigned WORD_W = 32;

  typedef struct packed {
    logic start;
  } seq_req_t;

  typedef struct packed {
    logic done;
    logic bank;
  } seq_stat_t;

  typedef struct packed {
    logic              en;
    logic              bank;
    logic [WORD_W-1:0] data;
  } seq_wr_t;

endpackage

@@ rtl/core/sms_ram.sv @@
// ----------------------------------------------------------------------------
// sms_ram
// Word buffer with one write port and two registered read ports.
// ----------------------------------------------------------------------------
module sms_ram
  import sms_pkg::*;
#(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = 5
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AW-1:0]     waddr_i,
  input  logic [WORD_W-1:0] wdata_i,
  input  logic [AW-1:0]     raddr_a_i,
  input  logic [AW-1:0]     raddr_b_i,
  output logic [WORD_W-1:0] rdata_a_o,
  output logic [WORD_W-1:0] rdata_b_o
);

  logic [WORD_W-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

@@ rtl/core/sms_merge_seq.sv @@
// ----------------------------------------------------------------------------
// sms_merge_seq
// Bottom-up merge pass sequencer around one shared signed compare/select.
// Passes alternate between the two buffer banks.
// ----------------------------------------------------------------------------
module sms_merge_seq
  import sms_pkg::*;
#(
  parameter int unsigned AW = 5,
  parameter int unsigned CW = 6
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  seq_req_t          req_i,
  input  logic [CW-1:0]     n_i,
  input  logic [WORD_W-1:0] rd_a_i,
  input  logic [WORD_W-1:0] rd_b_i,
  output logic [AW-1:0]     rd_addr_a_o,
  output logic [AW-1:0]     rd_addr_b_o,
  output seq_wr_t           wr_o,
  output logic [AW-1:0]     wr_addr_o,
  output seq_stat_t         stat_o
);

  localparam int unsigned SW = CW + 2;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SEG   = 4'b0010,
    S_READ  = 4'b0100,
    S_WRITE = 4'b1000
  } seq_state_e;

  seq_state_e    state_q, state_d;
  logic          bank_q, bank_d;
  logic          done_q, done_d;
  logic [CW-1:0] n_q, n_d;
  logic [CW-1:0] w_q, w_d;
  logic [CW-1:0] lo_q, lo_d;
  logic [CW-1:0] mid_q, mid_d;
  logic [CW-1:0] hi_q, hi_d;
  logic [CW-1:0] i_q, i_d;
  logic [CW-1:0] j_q, j_d;
  logic [CW-1:0] k_q, k_d;

  logic [SW-1:0] sum_mid, sum_hi, w2, n_w;
  logic          i_lt, j_lt, take_a, k_last;

  always_comb begin
    sum_mid = SW'(lo_q) + SW'(w_q);
    w2      = SW'(w_q) << 1;
    sum_hi  = SW'(lo_q) + w2;
    n_w     = SW'(n_q);
    i_lt    = i_q < mid_q;
    j_lt    = j_q < hi_q;
    take_a  = i_lt && (!j_lt || ($signed(rd_a_i) <= $signed(rd_b_i)));
    k_last  = (k_q + CW'(1)) == hi_q;
  end

  always_comb begin
    state_d = state_q;
    bank_d  = bank_q;
    done_d  = 1'b0;
    n_d     = n_q;
    w_d     = w_q;
    lo_d    = lo_q;
    mid_d   = mid_q;
    hi_d    = hi_q;
    i_d     = i_q;
    j_d     = j_q;
    k_d     = k_q;
    wr_o    = '{en: 1'b0, bank: ~bank_q, data: take_a ? rd_a_i : rd_b_i};
    case (state_q)
      S_IDLE: begin
        if (req_i.start) begin
          n_d    = n_i;
          w_d    = CW'(1);
          lo_d   = '0;
          bank_d = 1'b0;
          if (n_i <= CW'(1)) begin
            done_d = 1'b1;
          end else begin
            state_d = S_SEG;
          end
        end
      end
      S_SEG: begin
        mid_d   = (sum_mid < n_w) ? CW'(sum_mid) : n_q;
        hi_d    = (sum_hi < n_w) ? CW'(sum_hi) : n_q;
        i_d     = lo_q;
        j_d     = mid_d;
        k_d     = lo_q;
        state_d = S_READ;
      end
      S_READ: begin
        state_d = S_WRITE;
      end
      S_WRITE: begin
        wr_o.en = 1'b1;
        k_d     = k_q + CW'(1);
        if (take_a) begin
          i_d = i_q + CW'(1);
        end else begin
          j_d = j_q + CW'(1);
        end
        if (k_last) begin
          if (sum_hi >= n_w) begin
            bank_d = ~bank_q;
            lo_d   = '0;
            if (w2 >= n_w) begin
              done_d  = 1'b1;
              state_d = S_IDLE;
            end else begin
              w_d     = CW'(w2);
              state_d = S_SEG;
            end
          end else begin
            lo_d    = CW'(sum_hi);
            state_d = S_SEG;
          end
        end else begin
          state_d = S_READ;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      bank_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      bank_q  <= bank_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q   <= n_d;
    w_q   <= w_d;
    lo_q  <= lo_d;
    mid_q <= mid_d;
    hi_q  <= hi_d;
    i_q   <= i_d;
    j_q   <= j_d;
    k_q   <= k_d;
  end

  assign rd_addr_a_o = i_q[AW-1:0];
  assign rd_addr_b_o = j_q[AW-1:0];
  assign wr_addr_o   = k_q[AW-1:0];
  assign stat_o      = '{done: done_q, bank: bank_q};

endmodule

@@ rtl/core/stable_merge_sorter.sv @@
// Loading: one transaction per cycle; after the closing transaction the sort
// takes ceil(log2 n) passes, each setting up and merging every segment in turn,
// through the shared compare/select unit and its two-port buffer banks.
// Output: each result is fetched from the buffer, then shown until the sink takes it.
// Throughput: one set at a time; input is not accepted while sorting or emitting.
// Reset: counters, overflow flag and state machines clear at once; buffers and the sequencer's indices are not.
// ----------------------------------------------------------------------------
// stable_merge_sorter
// Collects a set of signed words, sorts it with a stable bottom-up merge
// sort over two ping-pong banks, and streams the sorted set out.
// ----------------------------------------------------------------------------
`include "stable_merge_sorter_defines.svh"

module stable_merge_sorter
  import sms_pkg::*;
#(
  parameter int unsigned MAX_ITEMS = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  logic [WORD_W-1:0] s_axis_tdata_i,   // [31:0] value
  input  logic              s_axis_tlast_i,
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  output logic [WORD_W-1:0] m_axis_tdata_o,   // [31:0] sorted_value
  output logic              m_axis_tlast_o,
  output logic              m_axis_tuser_o    // [0] overflow
);

  localparam int unsigned AW = $clog2(MAX_ITEMS);
  localparam int unsigned CW = $clog2(MAX_ITEMS + 1);

  typedef enum logic [3:0] {
    T_LOAD  = 4'b0001,
    T_SORT  = 4'b0010,
    T_FETCH = 4'b0100,
    T_SHOW  = 4'b1000
  } top_state_e;

  top_state_e    state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic          dropped_q, dropped_d;
  logic          start_q, start_d;
  logic [AW-1:0] emit_q, emit_d;

  logic          in_acc, out_acc, load_we, is_final;
  seq_req_t      seq_req;
  seq_wr_t       seq_wr;
  seq_stat_t     seq_stat;
  logic [AW-1:0] seq_addr_a, seq_addr_b, seq_waddr, rd_addr_a;

  logic              b0_we, b1_we;
  logic [AW-1:0]     b0_waddr;
  logic [WORD_W-1:0] b0_wdata;
  logic [WORD_W-1:0] b0_rd_a, b0_rd_b, b1_rd_a, b1_rd_b, src_a, src_b;

  assign s_axis_tready_o = (state_q == T_LOAD);
  assign m_axis_tvalid_o = (state_q == T_SHOW);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign out_acc         = m_axis_tvalid_o && m_axis_tready_i;
  assign is_final        = (CW'(emit_q) + CW'(1)) == count_q;

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    dropped_d = dropped_q;
    start_d   = 1'b0;
    emit_d    = emit_q;
    load_we   = 1'b0;
    case (state_q)
      T_LOAD: begin
        if (in_acc) begin
          if (count_q < CW'(MAX_ITEMS)) begin
            load_we = 1'b1;
            count_d = count_q + CW'(1);
          end else begin
            dropped_d = 1'b1;
          end
          if (s_axis_tlast_i) begin
            start_d = 1'b1;
            state_d = T_SORT;
          end
        end
      end
      T_SORT: begin
        if (seq_stat.done) begin
          emit_d  = '0;
          state_d = T_FETCH;
        end
      end
      T_FETCH: begin
        state_d = T_SHOW;
      end
      T_SHOW: begin
        if (out_acc) begin
          if (is_final) begin
            count_d   = '0;
            dropped_d = 1'b0;
            state_d   = T_LOAD;
          end else begin
            emit_d  = emit_q + AW'(1);
            state_d = T_FETCH;
          end
        end
      end
      default: begin
        state_d = T_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= T_LOAD;
      count_q   <= '0;
      dropped_q <= 1'b0;
      start_q   <= 1'b0;
      emit_q    <= '0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      dropped_q <= dropped_d;
      start_q   <= start_d;
      emit_q    <= emit_d;
    end
  end

  assign seq_req = '{start: start_q};

  sms_merge_seq #(
    .AW(AW),
    .CW(CW)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (seq_req),
    .n_i        (count_q),
    .rd_a_i     (src_a),
    .rd_b_i     (src_b),
    .rd_addr_a_o(seq_addr_a),
    .rd_addr_b_o(seq_addr_b),
    .wr_o       (seq_wr),
    .wr_addr_o  (seq_waddr),
    .stat_o     (seq_stat)
  );

  assign rd_addr_a = (state_q == T_FETCH || state_q == T_SHOW) ? emit_q : seq_addr_a;

  assign b0_we    = load_we || (seq_wr.en && !seq_wr.bank);
  assign b1_we    = seq_wr.en && seq_wr.bank;
  assign b0_waddr = load_we ? count_q[AW-1:0] : seq_waddr;
  assign b0_wdata = load_we ? s_axis_tdata_i : seq_wr.data;

  sms_ram #(
    .DEPTH(MAX_ITEMS),
    .AW   (AW)
  ) u_elem (
    .clk_i    (clk_i),
    .we_i     (b0_we),
    .waddr_i  (b0_waddr),
    .wdata_i  (b0_wdata),
    .raddr_a_i(rd_addr_a),
    .raddr_b_i(seq_addr_b),
    .rdata_a_o(b0_rd_a),
    .rdata_b_o(b0_rd_b)
  );

  sms_ram #(
    .DEPTH(MAX_ITEMS),
    .AW   (AW)
  ) u_scratch (
    .clk_i    (clk_i),
    .we_i     (b1_we),
    .waddr_i  (seq_waddr),
    .wdata_i  (seq_wr.data),
    .raddr_a_i(rd_addr_a),
    .raddr_b_i(seq_addr_b),
    .rdata_a_o(b1_rd_a),
    .rdata_b_o(b1_rd_b)
  );

  assign src_a = seq_stat.bank ? b1_rd_a : b0_rd_a;
  assign src_b = seq_stat.bank ? b1_rd_b : b0_rd_b;

  assign m_axis_tdata_o = src_a;
  assign m_axis_tlast_o = is_final;
  assign m_axis_tuser_o = dropped_q;

  `SMS_ASSERT_IMP(a_one_side, clk_i, rst_ni, s_axis_tready_o, !m_axis_tvalid_o, "in and out both open")
  `SMS_ASSERT_NXT(a_reload, clk_i, rst_ni, out_acc && m_axis_tlast_o, s_axis_tready_o, "no reload after run")
  `SMS_ASSERT_IMP(a_count_cap, clk_i, rst_ni, 1'b1, count_q <= CW'(MAX_ITEMS), "count beyond capacity")
  `SMS_ASSERT_IMP(a_merge_wr, clk_i, rst_ni, seq_wr.en, state_q == T_SORT, "merge write outside sort")

endmodule

@@ test/stable_merge_sorter_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stable_merge_sorter_tb
// Streams sets of signed words into the sorter and compares every sorted
// result, with its last and overflow marks, against an in-bench stable sort.
// Covers field extremes, duplicates, full and overfilled sets, long sink
// back-pressure and random sets under bursty traffic on both sides.
// ----------------------------------------------------------------------------
module stable_merge_sorter_tb
  import sms_pkg::*;
();

  localparam int unsigned MAX_ITEMS  = 32;
  localparam int unsigned IDLE_LIMIT = 5000;
  localparam int unsigned TOTAL_WORDS = 480;
  localparam int unsigned MAX_ERR_LINES = 30;

  typedef enum int {RX_STREAM, RX_LIGHT, RX_HEAVY, RX_TOGGLE} rx_style_e;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              last_flag;
    logic              ovf;
  } sorted_word_t;

  logic              clk_i;
  logic              rst_ni          = 1'b0;
  logic              s_axis_tvalid_i = 1'b0;
  logic              s_axis_tready_o;
  logic [WORD_W-1:0] s_axis_tdata_i  = '0;  // [31:0] value
  logic              s_axis_tlast_i  = 1'b0;
  logic              m_axis_tvalid_o;
  logic              m_axis_tready_i = 1'b0;
  logic [WORD_W-1:0] m_axis_tdata_o;        // [31:0] sorted_value
  logic              m_axis_tlast_o;
  logic              m_axis_tuser_o;        // [0] overflow

  stable_merge_sorter #(
    .MAX_ITEMS(MAX_ITEMS)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tlast_i (s_axis_tlast_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // predictor state
  logic signed [WORD_W-1:0] open_set_q[$];
  logic                     open_dropped;
  sorted_word_t             sorted_due_q[$];

  int unsigned mismatch_count;
  int unsigned words_sent;
  int unsigned sets_closed;
  int unsigned overfull_sets;
  int unsigned results_seen;

  // sender burst control
  bit          tx_gaps_on;
  int unsigned tx_burst_left;

  // sink hold-off request
  logic        rx_hold_req = 1'b0;
  logic        rx_hold_ack = 1'b0;
  int unsigned rx_hold_len;
  int unsigned rx_hold_left;
  rx_style_e   rx_style = RX_STREAM;
  int unsigned rx_phase_left;

  int unsigned idle_cycles;

  task automatic report_mismatch(input string msg);
    if (mismatch_count < MAX_ERR_LINES) $display("%0t mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  // Stable ascending sort of the closed set, one expected result per stored word.
  function automatic void predict_word(input logic [WORD_W-1:0] word, input logic last);
    logic signed [WORD_W-1:0] ordered[$];
    logic signed [WORD_W-1:0] key;
    sorted_word_t             res;
    int                       j;
    if (open_set_q.size() < MAX_ITEMS) open_set_q.push_back(word);
    else open_dropped = 1'b1;
    if (!last) return;
    ordered = open_set_q;
    for (int i = 1; i < ordered.size(); i++) begin
      key = ordered[i];
      j = i - 1;
      while (j >= 0 && ordered[j] > key) begin
        ordered[j + 1] = ordered[j];
        j--;
      end
      ordered[j + 1] = key;
    end
    for (int i = 0; i < ordered.size(); i++) begin
      res.word      = ordered[i];
      res.last_flag = (i == ordered.size() - 1);
      res.ovf       = open_dropped;
      sorted_due_q.push_back(res);
    end
    sets_closed++;
    if (open_dropped) overfull_sets++;
    open_set_q.delete();
    open_dropped = 1'b0;
  endfunction

  // Called in the time step of a rising edge; returns in the step of acceptance.
  task automatic offer_word(input logic [WORD_W-1:0] word, input logic last);
    int unsigned gap;
    if (tx_gaps_on && tx_burst_left == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 4);
      if (gap != 0) begin
        s_axis_tvalid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      tx_burst_left = $urandom_range(1, 20);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= word;
    s_axis_tlast_i  <= last;
    do @(posedge clk_i); while (!s_axis_tready_o);
    predict_word(word, last);
    words_sent++;
    if (tx_burst_left != 0) tx_burst_left--;
  endtask

  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return $urandom_range(0, 1) ? 32'h0000_0000 : 32'hFFFF_FFFF;
      3, 4, 5: return WORD_W'($signed($urandom_range(0, 16)) - 8);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_set(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) offer_word(pick_word(), i == len - 1);
  endtask

  task automatic wait_drained();
    while (sorted_due_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic idle_sender_until_drained();
    s_axis_tvalid_i <= 1'b0;
    wait_drained();
    @(posedge clk_i);
    tx_burst_left = 0;
  endtask

  task automatic test_directed();
    logic [WORD_W-1:0] mix[8];
    logic [WORD_W-1:0] dup[5];
    mix = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF,
            32'h0000_0001, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000};
    dup = '{32'd5, 32'hFFFF_FFFD, 32'd5, 32'hFFFF_FFFD, 32'd5};
    tx_gaps_on = 1'b0;
    offer_word(32'h8000_0000, 1'b1);
    offer_word(32'h7FFF_FFFF, 1'b1);
    foreach (mix[i]) offer_word(mix[i], i == 7);
    foreach (dup[i]) offer_word(dup[i], i == 4);
    offer_word(32'd7, 1'b0);
    offer_word(32'hFFFF_FFF9, 1'b1);
    idle_sender_until_drained();
  endtask

  // Exactly full, one dropped closing word, several dropped words.
  task automatic test_capacity();
    tx_gaps_on = 1'b1;
    send_set(MAX_ITEMS);
    send_set(MAX_ITEMS + 1);
    idle_sender_until_drained();
    send_set(MAX_ITEMS + 4);
    idle_sender_until_drained();
  endtask

  // Sink holds off while the source keeps offering, so the input stalls.
  task automatic test_backpressure();
    tx_gaps_on = 1'b0;
    rx_hold_len <= 400;
    rx_hold_req <= ~rx_hold_req;
    send_set(8);
    send_set(8);
    send_set(3);
    idle_sender_until_drained();
  endtask

  task automatic test_random();
    int unsigned len;
    int unsigned sel;
    tx_gaps_on = 1'b1;
    while (words_sent < TOTAL_WORDS) begin
      sel = $urandom_range(0, 19);
      if (sel == 0) len = $urandom_range(MAX_ITEMS, MAX_ITEMS + 8);
      else if (sel < 4) len = $urandom_range(9, MAX_ITEMS - 1);
      else len = $urandom_range(1, 8);
      send_set(len);
      if ($urandom_range(0, 9) == 0) idle_sender_until_drained();
    end
    idle_sender_until_drained();
  endtask

  // result checker
  always @(posedge clk_i) begin
    sorted_word_t due;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      results_seen++;
      if (sorted_due_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h", m_axis_tdata_o));
      end else begin
        due = sorted_due_q.pop_front();
        if (m_axis_tdata_o !== due.word)
          report_mismatch($sformatf("value %h, want %h", m_axis_tdata_o, due.word));
        if (m_axis_tlast_o !== due.last_flag)
          report_mismatch($sformatf("tlast %b, want %b", m_axis_tlast_o, due.last_flag));
        if (m_axis_tuser_o !== due.ovf)
          report_mismatch($sformatf("overflow %b, want %b", m_axis_tuser_o, due.ovf));
      end
    end
  end

  // sink ready pattern
  always @(posedge clk_i) begin
    if (rx_hold_req != rx_hold_ack) begin
      rx_hold_ack     <= rx_hold_req;
      rx_hold_left    <= rx_hold_len;
      m_axis_tready_i <= 1'b0;
    end else if (rx_hold_left != 0) begin
      rx_hold_left    <= rx_hold_left - 1;
      m_axis_tready_i <= 1'b0;
    end else begin
      if (rx_phase_left == 0) begin
        rx_style      <= rx_style_e'($urandom_range(0, 3));
        rx_phase_left <= $urandom_range(8, 80);
      end else begin
        rx_phase_left <= rx_phase_left - 1;
      end
      case (rx_style)
        RX_STREAM: m_axis_tready_i <= 1'b1;
        RX_LIGHT:  m_axis_tready_i <= ($urandom_range(0, 3) != 0);
        RX_HEAVY:  m_axis_tready_i <= ($urandom_range(0, 3) == 0);
        RX_TOGGLE: m_axis_tready_i <= rx_phase_left[0];
        default:   m_axis_tready_i <= 1'b1;
      endcase
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    idle_cycles = 0;
    wait (idle_cycles >= IDLE_LIMIT);
    $display("timeout after %0d cycles without a transaction", IDLE_LIMIT);
    $display("stable_merge_sorter_tb: FAIL");
    $finish;
  end

  initial begin
    open_dropped   = 1'b0;
    mismatch_count = 0;
    words_sent     = 0;
    sets_closed    = 0;
    overfull_sets  = 0;
    results_seen   = 0;
    tx_gaps_on     = 1'b0;
    tx_burst_left  = 0;
    rx_hold_len    = 0;
    rx_hold_left   = 0;
    rx_phase_left  = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_capacity();
    test_backpressure();
    test_random();

    wait_drained();
    repeat (60) @(posedge clk_i);
    if (sorted_due_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", sorted_due_q.size()));
    $display("covered %0d input transactions in %0d sets, %0d of them over capacity",
             words_sent, sets_closed, overfull_sets);
    $display("checked %0d sorted results, %0d mismatches", results_seen, mismatch_count);
    if (mismatch_count == 0) begin
      $display("stable_merge_sorter_tb: PASS");
    end else begin
      $display("stable_merge_sorter_tb: FAIL");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/sms_pkg.sv
rtl/core/sms_ram.sv
rtl/core/sms_merge_seq.sv
rtl/core/stable_merge_sorter.sv
test/stable_merge_sorter_tb.sv
